### rtl/slo_pkg.sv
// Shared types and constants for the sphere lattice overlap checker.
// Depends on nothing; every other file in rtl uses it.
package slo_pkg;

    // Fixed-point one in Q16.16, the radius after reset.
    localparam logic [30:0] ONE_Q = 31'd65536;

    // Operation codes.
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Status codes of a result word.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_SPACING = 2'd1;
    localparam logic [1:0] ST_FULL        = 2'd2;

    // Configuration register indexes.
    localparam int IDX_W = 4;
    localparam logic [IDX_W-1:0] REG_X_LENGTH  = 4'd0;
    localparam logic [IDX_W-1:0] REG_Y_LENGTH  = 4'd1;
    localparam logic [IDX_W-1:0] REG_Z_LENGTH  = 4'd2;
    localparam logic [IDX_W-1:0] REG_RADIUS    = 4'd3;
    localparam logic [IDX_W-1:0] REG_MARGIN    = 4'd4;
    localparam logic [IDX_W-1:0] REG_ORIGIN_X  = 4'd5;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Y  = 4'd6;
    localparam logic [IDX_W-1:0] REG_ORIGIN_Z  = 4'd7;

    // Axis count divider: dividend is length + margin + spacing - 1.
    localparam int DIV_N = 34;
    localparam int DIV_D = 32;

    // One stored sphere.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [31:0] r;
    } sphere_t;

endpackage

### rtl/slo_if.sv
// Handshake interfaces for the input, result and configuration channels.
// Depends on slo_pkg for the register index width.
interface slo_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic signed [31:0] query_z;
    logic        [30:0] query_radius;
    modport source (output valid, op, query_x, query_y, query_z, query_radius, input ready);
    modport sink   (input valid, op, query_x, query_y, query_z, query_radius, output ready);
endinterface

interface slo_out_if #(parameter int CNT_W = 13);
    logic             valid;
    logic             ready;
    logic             overlap;
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;
    modport source (output valid, overlap, status, entry_count, input ready);
    modport sink   (input valid, overlap, status, entry_count, output ready);
endinterface

interface slo_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [slo_pkg::IDX_W-1:0]     index;
    logic [31:0]                   data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/slo_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on slo_pkg for the operand widths.
module slo_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [slo_pkg::DIV_N-1:0]   dividend,
    input  logic [slo_pkg::DIV_D-1:0]   divisor,
    output logic                        done,
    output logic [slo_pkg::DIV_N-1:0]   quotient
);
    localparam int CW = $clog2(slo_pkg::DIV_N + 1);

    logic                        busy_reg, busy_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [slo_pkg::DIV_N-1:0]   quo_reg, quo_next;
    logic [slo_pkg::DIV_D-1:0]   rem_reg, rem_next;
    logic [slo_pkg::DIV_D-1:0]   dsr_reg, dsr_next;
    logic                        done_reg, done_next;
    logic [slo_pkg::DIV_D:0]     trial;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[slo_pkg::DIV_N-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = slo_pkg::DIV_D'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[slo_pkg::DIV_N-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[slo_pkg::DIV_D-1:0];
                quo_next = {quo_reg[slo_pkg::DIV_N-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(slo_pkg::DIV_N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state resets; the datapath does not need to.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

### rtl/sphere_lattice_overlap_check.sv
// Top level of the sphere lattice store with build and overlap query.
// Depends on slo_pkg, the interfaces in slo_if.sv and the divider slo_div.
//
//   channel   direction  payload
//   in_ch     sink       op, query_x, query_y, query_z, query_radius
//   out_ch    source     overlap, status, entry_count
//   cfg_ch    sink       index, data (always ready)
//
// A build runs three divisions, one per axis, then appends one sphere per
// cycle and hands off the word. A query reads the stored spheres in turn,
// and for a sphere inside the threshold box it forms t^2, dx^2, dy^2 and
// dz^2 in turn on the one shared multiplier.
// Reset empties the store at once; stored entries are not cleared.
// in_ch is ready only in idle; a finished word waits in the output register.
module sphere_lattice_overlap_check #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    slo_in_if.sink      in_ch,
    slo_out_if.source   out_ch,
    slo_cfg_if.sink     cfg_ch
);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int AD_W  = $clog2(STORE_DEPTH);
    localparam int AW    = CNT_W + 35;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_DIV   = 9'b000000010,
        S_BUILD = 9'b000000100,
        S_QRD   = 9'b000001000,
        S_QWAIT = 9'b000010000,
        S_QDIFF = 9'b000100000,
        S_QMUL  = 9'b001000000,
        S_QCMP  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [30:0]        xlen_reg, ylen_reg, zlen_reg, rad_reg, mar_reg;
    logic signed [31:0] orgx_reg, orgy_reg, orgz_reg;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xlen_reg <= '0;
            ylen_reg <= '0;
            zlen_reg <= '0;
            rad_reg  <= slo_pkg::ONE_Q;
            mar_reg  <= '0;
            orgx_reg <= '0;
            orgy_reg <= '0;
            orgz_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                slo_pkg::REG_X_LENGTH: xlen_reg <= cfg_ch.data[30:0];
                slo_pkg::REG_Y_LENGTH: ylen_reg <= cfg_ch.data[30:0];
                slo_pkg::REG_Z_LENGTH: zlen_reg <= cfg_ch.data[30:0];
                slo_pkg::REG_RADIUS:   rad_reg  <= cfg_ch.data[30:0];
                slo_pkg::REG_MARGIN:   mar_reg  <= cfg_ch.data[30:0];
                slo_pkg::REG_ORIGIN_X: orgx_reg <= cfg_ch.data;
                slo_pkg::REG_ORIGIN_Y: orgy_reg <= cfg_ch.data;
                slo_pkg::REG_ORIGIN_Z: orgz_reg <= cfg_ch.data;
                default: ;
            endcase
        end
    end

    // Lattice spacing 2r - m, and whether it is usable.
    logic signed [32:0] spacing;
    logic               spacing_ok;
    assign spacing    = $signed({1'b0, rad_reg, 1'b0}) - $signed({2'b0, mar_reg});
    assign spacing_ok = !spacing[32] && (spacing != '0);

    // Working registers.
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [1:0]                ax_reg, ax_next;
    logic [slo_pkg::DIV_N-1:0] nx_reg, ny_reg, nz_reg, nx_next, ny_next, nz_next;
    logic [CNT_W-1:0]          k_reg, j_reg, i_reg, k_next, j_next, i_next;
    logic signed [AW-1:0]      xa_reg, ya_reg, za_reg, xa_next, ya_next, za_next;
    logic [CNT_W-1:0]          e_reg, e_next;
    logic signed [31:0]        qx_reg, qy_reg, qz_reg, qx_next, qy_next, qz_next;
    logic [30:0]               qr_reg, qr_next;
    logic [31:0]               ut_reg, dx_reg, dy_reg, dz_reg;
    logic [31:0]               ut_next, dx_next, dy_next, dz_next;
    logic [2:0]                step_reg, step_next;
    logic [63:0]               prod_reg, prod_next, t2_reg, t2_next;
    logic [65:0]               sum_reg, sum_next;
    logic                      rov_reg, rov_next;
    logic [1:0]                rst_reg, rst_next;
    logic                      ov_reg, ov_next;
    logic                      oo_reg, oo_next;
    logic [1:0]                os_reg, os_next;
    logic [CNT_W-1:0]          oc_reg, oc_next;

    // Divider hookup; the dividend follows the axis chosen by div_sel.
    logic                      div_start, div_done;
    logic [1:0]                div_sel;
    logic [30:0]               div_len;
    logic [slo_pkg::DIV_N-1:0] div_a, div_q;

    always_comb
    begin
        unique case (div_sel)
            2'd0:    div_len = xlen_reg;
            2'd1:    div_len = ylen_reg;
            default: div_len = zlen_reg;
        endcase
        div_a = {3'b0, div_len} + {3'b0, mar_reg} + {2'b0, spacing[31:0]} - 1'b1;
    end

    slo_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (spacing[31:0]),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sphere store: one write and one registered read per cycle.
    slo_pkg::sphere_t mem [STORE_DEPTH];
    slo_pkg::sphere_t rd_q, wr_word;
    logic             wr_en;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[AD_W-1:0]] <= wr_word;
        end
        rd_q <= mem[e_reg[AD_W-1:0]];
    end

    // Lattice start points: origin plus radius on each axis.
    logic signed [AW-1:0] ox0, oy0, oz0, step_s;
    assign ox0    = AW'(orgx_reg) + AW'($signed({1'b0, rad_reg}));
    assign oy0    = AW'(orgy_reg) + AW'($signed({1'b0, rad_reg}));
    assign oz0    = AW'(orgz_reg) + AW'($signed({1'b0, rad_reg}));
    assign step_s = AW'(spacing);

    function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] hi, lo;
        hi = AW'(32'sh7fffffff);
        lo = AW'(-33'sh080000000);
        if (v > hi)
            sat32 = 32'sh7fffffff;
        else if (v < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = v[31:0];
    endfunction

    assign wr_word.x = sat32(xa_reg);
    assign wr_word.y = sat32(ya_reg);
    assign wr_word.z = sat32(za_reg);
    assign wr_word.r = {1'b0, rad_reg};

    // Query distances for the entry just read.
    logic signed [33:0] thr;
    logic signed [32:0] ddx, ddy, ddz;
    logic [32:0]        adx, ady, adz, ut33;
    logic               cand;
    assign thr  = $signed({3'b0, qr_reg}) + $signed({2'b0, rd_q.r})
                - $signed({3'b0, mar_reg});
    assign ddx  = $signed({rd_q.x[31], rd_q.x}) - $signed({qx_reg[31], qx_reg});
    assign ddy  = $signed({rd_q.y[31], rd_q.y}) - $signed({qy_reg[31], qy_reg});
    assign ddz  = $signed({rd_q.z[31], rd_q.z}) - $signed({qz_reg[31], qz_reg});
    assign adx  = ddx[32] ? 33'(-ddx) : ddx;
    assign ady  = ddy[32] ? 33'(-ddy) : ddy;
    assign adz  = ddz[32] ? 33'(-ddz) : ddz;
    assign ut33 = {1'b0, thr[31:0]};
    assign cand = !thr[33] && (thr != '0) && (adx < ut33) && (ady < ut33)
                && (adz < ut33);

    // Shared squarer operand.
    logic [31:0] mul_op;
    always_comb
    begin
        unique case (step_reg)
            3'd0:    mul_op = ut_reg;
            3'd1:    mul_op = dx_reg;
            3'd2:    mul_op = dy_reg;
            default: mul_op = dz_reg;
        endcase
    end

    logic last_k, last_j, last_i, last_e;
    assign last_k = (slo_pkg::DIV_N'(k_reg) + 1'b1) == nx_reg;
    assign last_j = (slo_pkg::DIV_N'(j_reg) + 1'b1) == ny_reg;
    assign last_i = (slo_pkg::DIV_N'(i_reg) + 1'b1) == nz_reg;
    assign last_e = (e_reg + 1'b1) == cnt_reg;

    assign in_ch.ready = (state_reg == S_IDLE);

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;  ax_next = ax_reg;
        nx_next = nx_reg;    ny_next = ny_reg;   nz_next = nz_reg;
        k_next = k_reg;      j_next = j_reg;     i_next = i_reg;
        xa_next = xa_reg;    ya_next = ya_reg;   za_next = za_reg;
        e_next = e_reg;
        qx_next = qx_reg;    qy_next = qy_reg;   qz_next = qz_reg;  qr_next = qr_reg;
        ut_next = ut_reg;    dx_next = dx_reg;   dy_next = dy_reg;  dz_next = dz_reg;
        step_next = step_reg;
        prod_next = prod_reg; t2_next = t2_reg;  sum_next = sum_reg;
        rov_next = rov_reg;  rst_next = rst_reg;
        ov_next = ov_reg;    oo_next = oo_reg;   os_next = os_reg;  oc_next = oc_reg;
        div_start = 1'b0;
        div_sel   = ax_reg;
        wr_en     = 1'b0;

        if (out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    qx_next  = in_ch.query_x;
                    qy_next  = in_ch.query_y;
                    qz_next  = in_ch.query_z;
                    qr_next  = in_ch.query_radius;
                    rov_next = 1'b0;
                    rst_next = slo_pkg::ST_OK;
                    e_next   = '0;
                    if (in_ch.op == slo_pkg::OP_QUERY)
                    begin
                        state_next = (cnt_reg == '0) ? S_DONE : S_QRD;
                    end
                    else if (!spacing_ok)
                    begin
                        rst_next   = slo_pkg::ST_BAD_SPACING;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ax_next    = 2'd0;
                        div_sel    = 2'd0;
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    unique case (ax_reg)
                        2'd0:    nx_next = div_q;
                        2'd1:    ny_next = div_q;
                        default: nz_next = div_q;
                    endcase
                    if (ax_reg == 2'd2)
                    begin
                        k_next = '0;  j_next = '0;  i_next = '0;
                        xa_next = ox0; ya_next = oy0; za_next = oz0;
                        state_next = (nx_reg == '0 || ny_reg == '0 || div_q == '0)
                                   ? S_DONE : S_BUILD;
                    end
                    else
                    begin
                        ax_next   = ax_reg + 1'b1;
                        div_sel   = ax_reg + 1'b1;
                        div_start = 1'b1;
                    end
                end
            end
            S_BUILD:
            begin
                if (cnt_reg == CNT_W'(STORE_DEPTH))
                begin
                    rst_next   = slo_pkg::ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    if (!last_k)
                    begin
                        k_next  = k_reg + 1'b1;
                        xa_next = xa_reg + step_s;
                    end
                    else
                    begin
                        k_next  = '0;
                        xa_next = ox0;
                        if (!last_j)
                        begin
                            j_next  = j_reg + 1'b1;
                            ya_next = ya_reg + step_s;
                        end
                        else
                        begin
                            j_next  = '0;
                            ya_next = oy0;
                            if (last_i)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                i_next  = i_reg + 1'b1;
                                za_next = za_reg + step_s;
                            end
                        end
                    end
                end
            end
            S_QRD:
            begin
                state_next = S_QWAIT;
            end
            S_QWAIT:
            begin
                state_next = S_QDIFF;
            end
            S_QDIFF:
            begin
                ut_next   = thr[31:0];
                dx_next   = adx[31:0];
                dy_next   = ady[31:0];
                dz_next   = adz[31:0];
                step_next = '0;
                if (cand)
                begin
                    state_next = S_QMUL;
                end
                else if (last_e)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_QRD;
                end
            end
            S_QMUL:
            begin
                // Square this operand while the previous square is summed.
                prod_next = mul_op * mul_op;
                step_next = step_reg + 1'b1;
                unique case (step_reg)
                    3'd0:    ;
                    3'd1:    t2_next  = prod_reg;
                    3'd2:    sum_next = {2'b0, prod_reg};
                    default: sum_next = sum_reg + {2'b0, prod_reg};
                endcase
                if (step_reg == 3'd4)
                begin
                    state_next = S_QCMP;
                end
            end
            S_QCMP:
            begin
                if (sum_reg < {2'b0, t2_reg})
                begin
                    rov_next   = 1'b1;
                    state_next = S_DONE;
                end
                else if (last_e)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    e_next     = e_reg + 1'b1;
                    state_next = S_QRD;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    oo_next    = rov_reg;
                    os_next    = rst_reg;
                    oc_next    = cnt_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            ax_reg    <= '0;
            step_reg  <= '0;
            e_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            ax_reg    <= ax_next;
            step_reg  <= step_next;
            e_reg     <= e_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        nx_reg <= nx_next;  ny_reg <= ny_next;  nz_reg <= nz_next;
        k_reg  <= k_next;   j_reg  <= j_next;   i_reg  <= i_next;
        xa_reg <= xa_next;  ya_reg <= ya_next;  za_reg <= za_next;
        qx_reg <= qx_next;  qy_reg <= qy_next;  qz_reg <= qz_next;  qr_reg <= qr_next;
        ut_reg <= ut_next;  dx_reg <= dx_next;  dy_reg <= dy_next;  dz_reg <= dz_next;
        prod_reg <= prod_next;
        t2_reg   <= t2_next;
        sum_reg  <= sum_next;
        rov_reg  <= rov_next;
        rst_reg  <= rst_next;
        oo_reg   <= oo_next;
        os_reg   <= os_next;
        oc_reg   <= oc_next;
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.overlap     = oo_reg;
    assign out_ch.status      = os_reg;
    assign out_ch.entry_count = oc_reg;
endmodule

### bench/tb_sphere_lattice_overlap_check.sv
// Self-checking bench for sphere_lattice_overlap_check: lattice builds and overlap queries.
// Depends on slo_pkg, the channel interfaces in slo_if.sv and the block under test.
`timescale 1ns / 100ps

module tb_sphere_lattice_overlap_check;

    localparam int DEPTH = 4096;
    localparam longint CYCLE_LIMIT = 40000000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        logic               op;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        logic signed [31:0] qz;
        logic        [30:0] qr;
    } probe_t;

    typedef struct {
        logic        overlap;
        logic [1:0]  status;
        logic [12:0] count;
    } reply_t;

    logic clk;
    logic rst_n;

    slo_in_if        in_ch();
    slo_out_if #(13) out_ch();
    slo_cfg_if       cfg_ch();

    sphere_lattice_overlap_check #(.STORE_DEPTH(DEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Shadow copy of the configuration and the sphere store.
    longint             plate_len[3];
    longint             lat_radius;
    longint             lat_margin;
    longint             lat_origin[3];
    logic signed [31:0] store_x[DEPTH];
    logic signed [31:0] store_y[DEPTH];
    logic signed [31:0] store_z[DEPTH];
    logic signed [31:0] store_r[DEPTH];
    int                 spheres_held;

    probe_t pending_probes[$];
    reply_t expected_replies[$];
    probe_t next_probe;
    bit     in_fire;
    int     send_idle_pct;
    int     recv_stall_pct;
    longint cycles;
    int     errors;
    int     words_checked;
    int     n_builds;
    int     n_queries;
    int     n_hits;
    int     n_bad_spacing;
    int     n_full;

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Appends the configured lattice to the shadow store and returns the status.
    function automatic logic [1:0] append_lattice();
        longint spacing;
        longint n[3];
        longint org[3];
        spacing = 2 * lat_radius - lat_margin;
        if (spacing <= 0) return slo_pkg::ST_BAD_SPACING;
        for (int a = 0; a < 3; a++)
        begin
            n[a] = (plate_len[a] + lat_margin + spacing - 1) / spacing;
            org[a] = lat_origin[a] + lat_radius;
        end
        if (n[0] == 0 || n[1] == 0 || n[2] == 0) return slo_pkg::ST_OK;
        for (longint i = 0; i < n[2]; i++)
            for (longint j = 0; j < n[1]; j++)
                for (longint k = 0; k < n[0]; k++)
                begin
                    if (spheres_held >= DEPTH) return slo_pkg::ST_FULL;
                    store_x[spheres_held] = clamp32(org[0] + k * spacing);
                    store_y[spheres_held] = clamp32(org[1] + j * spacing);
                    store_z[spheres_held] = clamp32(org[2] + i * spacing);
                    store_r[spheres_held] = lat_radius[31:0];
                    spheres_held++;
                end
        return slo_pkg::ST_OK;
    endfunction

    function automatic longint unsigned dist1(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        return (d < 0) ? -d : d;
    endfunction

    // True if the probe sphere overlaps any held sphere.
    function automatic bit sphere_overlaps(probe_t p);
        longint            t;
        longint unsigned   ut;
        longint unsigned   d[3];
        longint unsigned   sum;
        longint unsigned   sq;
        for (int e = 0; e < spheres_held; e++)
        begin
            t = longint'(p.qr) + longint'(store_r[e]) - lat_margin;
            if (t <= 0) continue;
            ut = t;
            d[0] = dist1(store_x[e], p.qx);
            d[1] = dist1(store_y[e], p.qy);
            d[2] = dist1(store_z[e], p.qz);
            if (d[0] >= ut || d[1] >= ut || d[2] >= ut) continue;
            sum = d[0] * d[0];
            for (int a = 1; a < 3; a++)
            begin
                sq = d[a] * d[a];
                sum = (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                           : sum + sq;
            end
            if (sum < ut * ut) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Clock and cycle limit.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding", cycles,
                     expected_replies.size());
            $display("tb_sphere_lattice_overlap_check NOT OK");
            $finish;
        end
    end

    // Input word driver: a word stays up until it is taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_fire)
            begin
                if (pending_probes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_probe = pending_probes.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.op           <= next_probe.op;
                    in_ch.query_x      <= next_probe.qx;
                    in_ch.query_y      <= next_probe.qy;
                    in_ch.query_z      <= next_probe.qz;
                    in_ch.query_radius <= next_probe.qr;
                end
                else
                    in_ch.valid <= 1'b0;
            end
            in_fire = 1'b0;
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Accepted input words update the shadow store and queue the expected reply.
    always @(posedge clk)
    begin
        probe_t p;
        reply_t r;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            in_fire = 1'b1;
            p.op = in_ch.op;
            p.qx = in_ch.query_x;
            p.qy = in_ch.query_y;
            p.qz = in_ch.query_z;
            p.qr = in_ch.query_radius;
            r.overlap = 1'b0;
            r.status = slo_pkg::ST_OK;
            if (p.op == slo_pkg::OP_BUILD)
            begin
                r.status = append_lattice();
                n_builds++;
                if (r.status == slo_pkg::ST_BAD_SPACING) n_bad_spacing++;
                if (r.status == slo_pkg::ST_FULL) n_full++;
            end
            else
            begin
                r.overlap = sphere_overlaps(p);
                n_queries++;
                if (r.overlap) n_hits++;
            end
            r.count = spheres_held[12:0];
            expected_replies = {expected_replies, r};
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_replies.size() == 0)
            begin
                $display("%0t: result word with none expected: overlap %0b status %0d count %0d",
                         $time, out_ch.overlap, out_ch.status, out_ch.entry_count);
                errors++;
            end
            else
            begin
                want = expected_replies.pop_front();
                words_checked++;
                if (out_ch.overlap !== want.overlap)
                begin
                    $display("%0t: overlap expected %0b actual %0b", $time, want.overlap,
                             out_ch.overlap);
                    errors++;
                end
                if (out_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             out_ch.status);
                    errors++;
                end
                if (out_ch.entry_count !== want.count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                             out_ch.entry_count);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [slo_pkg::IDX_W-1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        case (idx)
            slo_pkg::REG_X_LENGTH: plate_len[0] = value[30:0];
            slo_pkg::REG_Y_LENGTH: plate_len[1] = value[30:0];
            slo_pkg::REG_Z_LENGTH: plate_len[2] = value[30:0];
            slo_pkg::REG_RADIUS:   lat_radius   = value[30:0];
            slo_pkg::REG_MARGIN:   lat_margin   = value[30:0];
            slo_pkg::REG_ORIGIN_X: lat_origin[0] = longint'(signed'(value));
            slo_pkg::REG_ORIGIN_Y: lat_origin[1] = longint'(signed'(value));
            slo_pkg::REG_ORIGIN_Z: lat_origin[2] = longint'(signed'(value));
            default: ;
        endcase
    endtask

    task automatic set_lattice(longint lx, longint ly, longint lz, longint r, longint m,
                               longint ox, longint oy, longint oz);
        write_reg(slo_pkg::REG_X_LENGTH, lx[31:0]);
        write_reg(slo_pkg::REG_Y_LENGTH, ly[31:0]);
        write_reg(slo_pkg::REG_Z_LENGTH, lz[31:0]);
        write_reg(slo_pkg::REG_RADIUS, r[31:0]);
        write_reg(slo_pkg::REG_MARGIN, m[31:0]);
        write_reg(slo_pkg::REG_ORIGIN_X, ox[31:0]);
        write_reg(slo_pkg::REG_ORIGIN_Y, oy[31:0]);
        write_reg(slo_pkg::REG_ORIGIN_Z, oz[31:0]);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Waits until every word has been taken and answered, then a little longer.
    task automatic drain();
        while (pending_probes.size() > 0 || in_ch.valid || expected_replies.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_word(logic op, longint x, longint y, longint z, longint r);
        probe_t p;
        p.op = op;
        p.qx = x[31:0];
        p.qy = y[31:0];
        p.qz = z[31:0];
        p.qr = r[30:0];
        pending_probes = {pending_probes, p};
    endtask

    // A random word: mostly queries aimed at the current lattice.
    task automatic queue_random_word();
        longint spacing;
        longint c[3];
        spacing = 2 * lat_radius - lat_margin;
        if (spacing <= 0) spacing = lat_radius;
        if ($urandom_range(3) == 0)
            queue_word(slo_pkg::OP_BUILD, $urandom, $urandom, $urandom, $urandom);
        else if ($urandom_range(4) == 0)
            queue_word(slo_pkg::OP_QUERY, $urandom, $urandom, $urandom, $urandom);
        else
        begin
            for (int a = 0; a < 3; a++)
                c[a] = lat_origin[a] + lat_radius + longint'($urandom_range(0, 3)) * spacing
                       + longint'($urandom_range(0, 2 * 65536)) - 65536;
            queue_word(slo_pkg::OP_QUERY, c[0], c[1], c[2],
                       $urandom_range(0, int'(2 * lat_radius + 65536)));
        end
    endtask

    task automatic random_lattice();
        longint r;
        longint m;
        longint s;
        longint l[3];
        longint o[3];
        r = $urandom_range(1, 1 << 20);
        if ($urandom_range(5) == 0)
            m = 2 * r + $urandom_range(0, 100);
        else
            m = $urandom_range(0, int'(r));
        s = 2 * r - m;
        for (int a = 0; a < 3; a++)
        begin
            l[a] = (s > 0) ? longint'($urandom_range(0, int'(2 * s - m))) : $urandom_range(0, 1000);
            if ($urandom_range(3) == 0)
                o[a] = longint'(signed'($urandom));
            else
                o[a] = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
        end
        set_lattice(l[0], l[1], l[2], r, m, o[0], o[1], o[2]);
    endtask

    task automatic idle_mode(int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 38; recv_stall_pct = 38; end
        endcase
    endtask

    // Stimulus sequence.
    initial
    begin
        longint fill;
        in_ch.valid = 1'b0;
        in_ch.op = slo_pkg::OP_BUILD;
        in_ch.query_x = '0;
        in_ch.query_y = '0;
        in_ch.query_z = '0;
        in_ch.query_radius = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        plate_len = '{0, 0, 0};
        lat_origin = '{0, 0, 0};
        lat_radius = slo_pkg::ONE_Q;
        lat_margin = 0;
        spheres_held = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: query on an empty store, then a zero-size lattice.
        queue_word(slo_pkg::OP_QUERY, -64'sd2147483648, 64'sd2147483647, 0, 64'h7FFFFFFF);
        queue_word(slo_pkg::OP_BUILD, 0, 0, 0, 0);
        drain();

        // Two spheres whose x coordinate saturates at the top of the range.
        set_lattice(32'h30000, 32'h10000, 1, 32'h10000, 0, 32'h7FFF0000, 32'h80000000, 0);
        queue_word(slo_pkg::OP_BUILD, 0, 0, 0, 0);
        queue_word(slo_pkg::OP_QUERY, 32'h7FFFFFFF, -64'sd2147483648 + 32'h10000, 32'h10000, 0);
        queue_word(slo_pkg::OP_QUERY, 0, 0, 0, 32'h100);
        queue_word(slo_pkg::OP_QUERY, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647,
                   32'h7FFFFFFF);
        queue_word(slo_pkg::OP_QUERY, 32'h7FFD0000, -64'sd2147483648 + 32'h10000, 32'h10000,
                   32'h10000);
        drain();

        // Margin of twice the radius: no spacing, and a threshold that only the larger query radius makes positive.
        set_lattice(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h10000, 32'h20000,
                    32'h80000000, 32'h7FFFFFFF, 0);
        queue_word(slo_pkg::OP_BUILD, 0, 0, 0, 0);
        queue_word(slo_pkg::OP_QUERY, 32'h7FFFFFFF, -64'sd2147483648 + 32'h10000, 32'h10000, 0);
        queue_word(slo_pkg::OP_QUERY, 32'h7FFFFFFF, -64'sd2147483648 + 32'h10000, 32'h10000,
                   32'h10001);
        drain();

        // Largest radius, margin and lengths: a 2x2x2 lattice of huge spheres.
        set_lattice(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
        queue_word(slo_pkg::OP_BUILD, 0, 0, 0, 0);
        queue_word(slo_pkg::OP_QUERY, 0, 0, 0, 0);
        queue_word(slo_pkg::OP_QUERY, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        queue_word(slo_pkg::OP_QUERY, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 1);
        drain();

        // Random phases, each with its own lattice and idling pattern.
        for (int phase = 0; phase < 8; phase++)
        begin
            random_lattice();
            idle_mode(phase);
            for (int n = 0; n < 15; n++) queue_random_word();
            drain();
        end

        // Fill the store exactly, then overflow it; queries then walk the full store.
        idle_mode(3);
        fill = DEPTH - spheres_held;
        set_lattice(fill * 32'h20000, 1, 1, 32'h10000, 0, 0, 0, 0);
        queue_word(slo_pkg::OP_BUILD, 0, 0, 0, 0);
        queue_word(slo_pkg::OP_BUILD, 0, 0, 0, 0);
        queue_word(slo_pkg::OP_QUERY, 32'h10000 + 32'h20000 * (fill - 1), 32'h10000, 32'h10000, 0);
        queue_word(slo_pkg::OP_QUERY, 32'h10000, 32'h14000, 32'h10000, 32'h1000);
        queue_word(slo_pkg::OP_QUERY, -64'sd2147483648, 32'h10000, 32'h10000, 32'h10000);
        queue_word(slo_pkg::OP_QUERY, $urandom, $urandom, $urandom, $urandom);
        drain();

        $display("checked %0d result words: %0d builds (%0d bad spacing, %0d full), %0d queries",
                 words_checked, n_builds, n_bad_spacing, n_full, n_queries);
        $display("%0d queries overlapped; store ended with %0d spheres", n_hits, spheres_held);
        if (errors == 0)
            $display("tb_sphere_lattice_overlap_check OK");
        else
            $display("tb_sphere_lattice_overlap_check NOT OK");
        $finish;
    end

endmodule

### sphere_lattice_overlap_check.f
rtl/slo_pkg.sv
rtl/slo_if.sv
rtl/slo_div.sv
rtl/sphere_lattice_overlap_check.sv
bench/tb_sphere_lattice_overlap_check.sv
